// ===== src/gls_pkg.sv =====
// Shared types and constants for the grid line-of-sight core.
// Used by gls_ctrl, gls_datapath and grid_line_of_sight_core; depends on nothing.
package gls_pkg;

  // Fixed widths of the request fields.
  localparam int unsigned CoordW = 18;
  localparam int unsigned IdxW   = 15;
  localparam int unsigned ValW   = 16;

  // Defaults for the top-level parameters.
  localparam int unsigned GridSideDef  = 128;
  localparam int unsigned TileTypesDef = 512;
  localparam int unsigned FracBitsDef  = 10;

  typedef enum logic [1:0] {
    OP_WR_TILE = 2'd0,
    OP_WR_SUB  = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SQUARE,
    ST_SQRT,
    ST_LEN,
    ST_DIVX,
    ST_DIVZ0,
    ST_DIVZ,
    ST_MINIT,
    ST_MARCH,
    ST_DRAIN,
    ST_REPORT
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_WR_TILE,
    CMD_WR_SUB,
    CMD_LOAD,
    CMD_DELTA,
    CMD_SQUARE,
    CMD_SQRT,
    CMD_DIVX_INIT,
    CMD_DIV_STEP,
    CMD_DIVZ_INIT,
    CMD_MARCH_INIT,
    CMD_MARCH
  } dp_cmd_e;

  typedef struct packed {
    logic len_zero;
    logic march_end;
    logic hit;
    logic pipe_busy;
  } dp_status_t;

endpackage

// ===== src/gls_ctrl.sv =====
// Sequencer for the line-of-sight core: walks a request through setup, root,
// divisions, march and drain. Depends on gls_pkg.
module gls_ctrl import gls_pkg::*; #(
  parameter int unsigned SqrtSteps = 19,
  parameter int unsigned DivSteps  = 27
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] opcode_i,
  input  dp_status_t status_i,
  output dp_cmd_e    cmd_o,
  output logic       busy,
  output logic       done_o
);

  localparam int unsigned CntW = $clog2(DivSteps + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = CMD_NONE;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (opcode_e'(opcode_i))
            OP_WR_TILE: cmd_o = CMD_WR_TILE;
            OP_WR_SUB:  cmd_o = CMD_WR_SUB;
            OP_QUERY: begin
              cmd_o   = CMD_LOAD;
              state_d = ST_DELTA;
            end
            default: cmd_o = CMD_NONE;
          endcase
        end
      end
      ST_DELTA: begin
        cmd_o   = CMD_DELTA;
        state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o   = CMD_SQUARE;
        cnt_d   = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o = CMD_SQRT;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        // A zero-length line is clear without any sample.
        if (status_i.len_zero) begin
          state_d = ST_REPORT;
        end else begin
          cmd_o   = CMD_DIVX_INIT;
          cnt_d   = '0;
          state_d = ST_DIVX;
        end
      end
      ST_DIVX: begin
        cmd_o = CMD_DIV_STEP;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ST_DIVZ0;
        end
      end
      ST_DIVZ0: begin
        cmd_o   = CMD_DIVZ_INIT;
        cnt_d   = '0;
        state_d = ST_DIVZ;
      end
      ST_DIVZ: begin
        cmd_o = CMD_DIV_STEP;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ST_MINIT;
        end
      end
      ST_MINIT: begin
        cmd_o   = CMD_MARCH_INIT;
        state_d = ST_MARCH;
      end
      ST_MARCH: begin
        cmd_o = CMD_MARCH;
        if (status_i.hit) begin
          state_d = ST_REPORT;
        end else if (status_i.march_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.hit || !status_i.pipe_busy) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/gls_datapath.sv =====
// Datapath of the line-of-sight core: tile and sub-cell memories, root and
// divider iterations, incremental march and the probe pipeline. Depends on gls_pkg.
module gls_datapath import gls_pkg::*; #(
  parameter int unsigned GridSide  = GridSideDef,
  parameter int unsigned TileTypes = TileTypesDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_e                  cmd_i,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_z_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_z_i,
  input  logic [IdxW-1:0]          table_index_i,
  input  logic [ValW-1:0]          table_value_i,
  output dp_status_t               status_o,
  output logic                     line_clear_o
);

  localparam int unsigned MagW      = CoordW;
  localparam int unsigned SqW       = 2 * MagW + 2;
  localparam int unsigned LenW      = MagW + 1;
  localparam int unsigned IncW      = MagW + FracBits - 1;
  localparam int unsigned QW        = IncW + 1;
  localparam int unsigned RemW      = LenW + 2;
  localparam int unsigned TW        = LenW + 1;
  localparam int unsigned SW        = CoordW + 2;
  localparam int unsigned CoW       = SW + 3;
  localparam int unsigned TileCells = GridSide * GridSide;
  localparam int unsigned SubCells  = TileTypes * 64;
  localparam int unsigned TaW       = $clog2(TileCells);
  localparam int unsigned TtW       = $clog2(TileTypes);
  localparam int unsigned SaW       = TtW + 6;
  localparam int unsigned GridOfs   = GridSide * 4 - 16;
  localparam int unsigned GridLim   = GridSide * 8;
  localparam int unsigned StepT     = 1 << (FracBits - 2);
  localparam int unsigned HalfQ     = 1 << (FracBits - 1);

  logic [ValW-1:0] tile_mem [TileCells];
  logic [7:0]      sub_mem  [SubCells];

  logic signed [CoordW-1:0] ax_q, az_q, bx_q, bz_q;
  logic [MagW-1:0]          mx_q, mz_q;
  logic                     nx_q, nz_q;
  logic [SqW-1:0]           rad_q, root_q, bit_q;
  logic [LenW:0]            den_q;
  logic [RemW-1:0]          rem_q;
  logic [IncW-1:0]          quo_q;
  logic [IncW-1:0]          qincx_q, qincz_q;
  logic [LenW:0]            rincx_q, rincz_q;
  logic [TW-1:0]            t_q;
  logic [QW-1:0]            qx_q, qz_q;
  logic [LenW:0]            rx_q, rz_q;
  logic                     va_q, vb_q, vc_q;
  logic signed [SW-1:0]     sxa_q, sza_q;
  logic [ValW-1:0]          tile_rd_q;
  logic [5:0]               cell_b_q;
  logic [7:0]               sub_rd_q;
  logic                     blocked_q;

  logic [31:0]              idx_ext;
  logic signed [CoordW:0]   dx, dz;
  logic [CoordW:0]          adx, adz;
  logic [2*MagW-1:0]        sqx, sqz;
  logic [SqW-1:0]           sq_sum, trial;
  logic [RemW-1:0]          rem_sh;
  logic [LenW+1:0]          rxs, rzs;
  logic                     cx, cz, samp_ok, skip;
  logic [LenW-1:0]          len;
  logic signed [SW-1:0]     sxs, szs;
  logic signed [CoW-1:0]    cb, rb;
  logic                     in_grid;
  logic [31:0]              tile_lin;
  logic                     tile_ok;
  logic [SaW-1:0]           sub_addr;
  logic                     hit;

  // Quarter-unit world coordinate rounded half away from zero, biased onto the grid.
  function automatic logic signed [CoW-1:0] to_grid(input logic signed [SW-1:0] s);
    logic [SW-1:0]  mag;
    logic [SW+1:0]  m4;
    logic [CoW-1:0] c4;
    mag = s[SW-1] ? SW'(-s) : SW'(s);
    m4  = {mag, 2'b00} + (SW + 2)'(HalfQ);
    c4  = CoW'(m4 >> FracBits);
    return s[SW-1] ? $signed(-c4) + $signed(CoW'(GridOfs))
                   : $signed(c4) + $signed(CoW'(GridOfs));
  endfunction

  assign idx_ext = 32'(table_index_i);
  assign len     = root_q[LenW-1:0];

  assign dx  = $signed({bx_q[CoordW-1], bx_q}) - $signed({ax_q[CoordW-1], ax_q});
  assign dz  = $signed({bz_q[CoordW-1], bz_q}) - $signed({az_q[CoordW-1], az_q});
  assign adx = dx[CoordW] ? (CoordW + 1)'(-dx) : (CoordW + 1)'(dx);
  assign adz = dz[CoordW] ? (CoordW + 1)'(-dz) : (CoordW + 1)'(dz);

  assign sqx    = mx_q * mx_q;
  assign sqz    = mz_q * mz_q;
  assign sq_sum = SqW'(sqx) + SqW'(sqz);
  assign trial  = root_q + bit_q;
  assign rem_sh = {rem_q[RemW-2:0], quo_q[IncW-1]};

  // Running remainders of the rounded quotients; each stays below twice den_q.
  assign rxs = (LenW + 2)'(rx_q) + (LenW + 2)'(rincx_q);
  assign rzs = (LenW + 2)'(rz_q) + (LenW + 2)'(rincz_q);
  assign cx  = rxs >= (LenW + 2)'(den_q);
  assign cz  = rzs >= (LenW + 2)'(den_q);

  assign samp_ok = (cmd_i == CMD_MARCH) && (t_q < TW'(len));
  assign skip    = (qx_q == '0) || (qz_q == '0);
  assign sxs = nx_q ? $signed(SW'(ax_q)) - $signed({1'b0, qx_q[SW-2:0]})
                    : $signed(SW'(ax_q)) + $signed({1'b0, qx_q[SW-2:0]});
  assign szs = nz_q ? $signed(SW'(az_q)) - $signed({1'b0, qz_q[SW-2:0]})
                    : $signed(SW'(az_q)) + $signed({1'b0, qz_q[SW-2:0]});

  assign cb      = to_grid(sxa_q);
  assign rb      = to_grid(sza_q);
  assign in_grid = !cb[CoW-1] && !rb[CoW-1] &&
                   (cb < $signed(CoW'(GridLim))) && (rb < $signed(CoW'(GridLim)));
  assign tile_lin = 32'(rb[CoW-1:3]) * 32'(GridSide) + 32'(cb[CoW-1:3]);

  assign tile_ok  = !tile_rd_q[ValW-1] && (tile_rd_q != '0) &&
                    (32'(tile_rd_q) < 32'(TileTypes));
  assign sub_addr = {tile_rd_q[TtW-1:0], cell_b_q};
  assign hit      = vc_q && ((sub_rd_q == 8'd0) || (sub_rd_q == 8'd3));

  assign status_o.len_zero  = (len == '0);
  assign status_o.march_end = (t_q >= TW'(len));
  assign status_o.hit       = hit;
  assign status_o.pipe_busy = va_q | vb_q | vc_q;
  assign line_clear_o       = !blocked_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_WR_TILE && idx_ext < 32'(TileCells)) begin
      tile_mem[idx_ext[TaW-1:0]] <= table_value_i;
    end
    if (cmd_i == CMD_WR_SUB && idx_ext < 32'(SubCells)) begin
      sub_mem[idx_ext[SaW-1:0]] <= table_value_i[7:0];
    end
    tile_rd_q <= tile_mem[tile_lin[TaW-1:0]];
    sub_rd_q  <= sub_mem[sub_addr];
  end

  // Arithmetic payload registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        ax_q <= start_x_i;
        az_q <= start_z_i;
        bx_q <= end_x_i;
        bz_q <= end_z_i;
      end
      CMD_DELTA: begin
        mx_q <= adx[MagW-1:0];
        mz_q <= adz[MagW-1:0];
        nx_q <= dx[CoordW];
        nz_q <= dz[CoordW];
      end
      CMD_SQUARE: begin
        rad_q  <= sq_sum;
        root_q <= '0;
        bit_q  <= SqW'(1) << (SqW - 2);
      end
      CMD_SQRT: begin
        if (rad_q >= trial) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      CMD_DIVX_INIT: begin
        den_q <= {len, 1'b0};
        rem_q <= '0;
        quo_q <= IncW'(mx_q) << (FracBits - 1);
      end
      CMD_DIV_STEP: begin
        if (rem_sh >= RemW'(den_q)) begin
          rem_q <= rem_sh - RemW'(den_q);
          quo_q <= {quo_q[IncW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[IncW-2:0], 1'b0};
        end
      end
      CMD_DIVZ_INIT: begin
        qincx_q <= quo_q;
        rincx_q <= rem_q[LenW:0];
        rem_q   <= '0;
        quo_q   <= IncW'(mz_q) << (FracBits - 1);
      end
      CMD_MARCH_INIT: begin
        qincz_q <= quo_q;
        rincz_q <= rem_q[LenW:0];
        t_q     <= '0;
        qx_q    <= '0;
        qz_q    <= '0;
        rx_q    <= (LenW + 1)'(len);
        rz_q    <= (LenW + 1)'(len);
      end
      CMD_MARCH: begin
        if (samp_ok) begin
          t_q  <= t_q + TW'(StepT);
          qx_q <= qx_q + QW'(qincx_q) + QW'(cx);
          qz_q <= qz_q + QW'(qincz_q) + QW'(cz);
          rx_q <= cx ? (LenW + 1)'(rxs - (LenW + 2)'(den_q)) : (LenW + 1)'(rxs);
          rz_q <= cz ? (LenW + 1)'(rzs - (LenW + 2)'(den_q)) : (LenW + 1)'(rzs);
        end
      end
      default: ;
    endcase
    sxa_q    <= sxs;
    sza_q    <= szs;
    cell_b_q <= {cb[2:0], rb[2:0]};
  end

  // Probe pipeline valids and the blocked flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      vc_q      <= 1'b0;
      blocked_q <= 1'b0;
    end else if (cmd_i == CMD_LOAD) begin
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      vc_q      <= 1'b0;
      blocked_q <= 1'b0;
    end else begin
      va_q <= samp_ok && !skip;
      vb_q <= va_q && in_grid;
      vc_q <= vb_q && tile_ok;
      if (hit) begin
        blocked_q <= 1'b1;
      end
    end
  end

endmodule

// ===== src/grid_line_of_sight_core.sv =====
// Top level of the grid line-of-sight core: controller plus datapath.
// Depends on gls_pkg, gls_ctrl and gls_datapath.
//
//  Channel   Handshake           Fields
//  request   start & !busy       opcode, start_x/z, end_x/z, table_index, table_value
//  result    done_o (one cycle)  line_clear_o
//
// A table write goes into its memory as it is accepted and leaves the core idle. A
// query runs a 19-step bit-serial square root for the segment length, then two 27-step
// divisions for the march increments and the march at one sample per cycle, and last
// drains the tile and sub-cell memory probes. A zero-length line skips the divisions
// and the march; a blocked sample ends a query early. The core takes a new request the
// cycle after the strobe.
// Reset clears the controller and pipeline valids; the tables stay undefined until written.
// The receiver cannot stall; busy stays high until the result strobe.
module grid_line_of_sight_core import gls_pkg::*; #(
  parameter int unsigned GRID_SIDE  = GridSideDef,
  parameter int unsigned TILE_TYPES = TileTypesDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode_i,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_z_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_z_i,
  input  logic [IdxW-1:0]          table_index_i,
  input  logic [ValW-1:0]          table_value_i,
  output logic                     done_o,
  output logic                     line_clear_o
);

  localparam int unsigned SqrtSteps = CoordW + 1;
  localparam int unsigned DivSteps  = CoordW + FRAC_BITS - 1;

  dp_cmd_e    cmd;
  dp_status_t status;

  gls_ctrl #(
    .SqrtSteps(SqrtSteps),
    .DivSteps (DivSteps)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .opcode_i(opcode_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy    (busy),
    .done_o  (done_o)
  );

  gls_datapath #(
    .GridSide (GRID_SIDE),
    .TileTypes(TILE_TYPES),
    .FracBits (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .start_x_i    (start_x_i),
    .start_z_i    (start_z_i),
    .end_x_i      (end_x_i),
    .end_z_i      (end_z_i),
    .table_index_i(table_index_i),
    .table_value_i(table_value_i),
    .status_o     (status),
    .line_clear_o (line_clear_o)
  );

  // A result strobe only comes out of a running query.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe while idle");

  // The strobe lasts one cycle and the core is free right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o && !busy)
    else $error("result strobe not followed by idle");

  // An accepted query keeps the core busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_QUERY) |=> busy && !done_o)
    else $error("query not taken up");

  // Table writes never start a query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_WR_TILE || opcode_i == OP_WR_SUB)) |=> !busy)
    else $error("write left the core busy");

endmodule
